/* hdl/amfu_pkg.sv */
// Shared constants, request codes and saturation helper for the AdaGrad factorization engine.
package amfu_pkg;

  localparam int NUM_USERS     = 1024;
  localparam int NUM_ITEMS     = 1024;
  localparam int FEATS_PER_ROW = 32;

  localparam int UADDR_W = $clog2(NUM_USERS * FEATS_PER_ROW);
  localparam int IADDR_W = $clog2(NUM_ITEMS * FEATS_PER_ROW);
  localparam int FI_W    = (FEATS_PER_ROW > 1) ? $clog2(FEATS_PER_ROW) : 1;
  localparam int SUM_W   = 32 + FI_W + 1;

  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 32;
  localparam int IT_W       = 6;

  localparam logic [15:0] LR_RESET  = 16'd655;
  localparam logic [15:0] REG_RESET = 16'd1311;

  typedef enum logic [2:0] {
    REQ_LOAD_USER = 3'd0,
    REQ_LOAD_ITEM = 3'd1,
    REQ_TRAIN     = 3'd2,
    REQ_READ_USER = 3'd3,
    REQ_READ_ITEM = 3'd4
  } req_t;

  localparam logic CFG_LEARNING_RATE = 1'b0;
  localparam logic CFG_REG_FACTOR    = 1'b1;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
    logic signed [15:0] r;
    if (x > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

/* hdl/adagrad_matrix_factor_update.sv */
// Top level of the AdaGrad matrix factorization engine with its feature and accumulator memories.
//
//  Channel   Direction  Handshake          Word
//  in_       input      in_valid/in_stall  req_type, ids, feature index, load value, rating
//  out_      output     out_valid/out_stall error, read_value
//  cfg_      input      cfg_valid/cfg_ready index, data
//
// For a train word, each feature runs the user and then the item element through one
// shared bit-per-cycle square root (24 steps plus a load step) and one bit-per-cycle
// divider (32 steps). One word is in work at a time.
// Reset is synchronous; the memories are not cleared. A waiting result holds until
// out_stall drops, and in_stall stays high until the engine is back in idle.
module adagrad_matrix_factor_update (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [9:0]         in_user_id,
  input  logic [9:0]         in_item_id,
  input  logic [4:0]         in_feature_index,
  input  logic signed [15:0] in_load_value,
  input  logic signed [15:0] in_rating,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_error,
  output logic signed [15:0] out_read_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int UAW = amfu_pkg::UADDR_W;
  localparam int IAW = amfu_pkg::IADDR_W;
  localparam int FW  = amfu_pkg::FI_W;
  localparam int SW  = amfu_pkg::SUM_W;
  localparam int ITW = amfu_pkg::IT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RWAIT, S_DOT, S_DRAIN, S_ERR, S_FRD, S_FLAT,
    S_GMUL, S_GSUM, S_SQ, S_ACC, S_SQRT, S_DIV, S_UPD, S_WB
  } state_t;

  state_t state_r;
  logic   done_r;

  logic [15:0] lr_r, rf_r;

  logic [2:0]         req_r;
  logic [9:0]         uid_r, iid_r;
  logic [4:0]         fi_r;
  logic signed [15:0] lv_r, rating_r;

  logic [15:0] uf_mem [2**UAW];
  logic [31:0] ua_mem [2**UAW];
  logic [15:0] if_mem [2**IAW];
  logic [31:0] ia_mem [2**IAW];
  logic [15:0] uf_rd_r, if_rd_r;
  logic [31:0] ua_rd_r, ia_rd_r;

  logic [FW-1:0]      f_r;
  logic [ITW-1:0]     it_r;
  logic               rdv_r, pv_r, side_r;
  logic signed [31:0] dot_r;
  logic signed [SW-1:0] sum_r;
  logic signed [15:0] err_r, u_r, v_r, g_r, rd_val_r;
  logic [31:0]        au_r, ai_r, a_r, sq_r;
  logic signed [32:0] p1_r;
  logic signed [31:0] p2_r;
  logic [47:0]        x_r;
  logic [23:0]        root_r;
  logic [26:0]        srem_r;
  logic [31:0]        num_r, q_r;
  logic [24:0]        drem_r;
  logic signed [48:0] prod_r;
  logic               out_valid_r;
  logic signed [15:0] out_error_r, out_read_value_r;

  logic               u_ok, i_ok, f_ok, f_last;
  logic [UAW-1:0]     uaddr;
  logic [IAW-1:0]     iaddr;
  logic [FW-1:0]      fsel;
  logic signed [15:0] own, other, nf;
  logic [31:0]        acc_sel, a_nz, sqr;
  logic [32:0]        a33;
  logic signed [47:0] ediff, gsum;
  logic signed [55:0] nwide;
  logic [26:0]        srem_sh, strial;
  logic [24:0]        drem_sh;
  logic               uwe, iwe, is_load;
  logic [15:0]        fwd;
  logic [31:0]        awd;

  assign u_ok   = 32'(uid_r) < amfu_pkg::NUM_USERS;
  assign i_ok   = 32'(iid_r) < amfu_pkg::NUM_ITEMS;
  assign f_ok   = 32'(fi_r) < amfu_pkg::FEATS_PER_ROW;
  assign f_last = f_r == FW'(amfu_pkg::FEATS_PER_ROW - 1);
  assign fsel   = (state_r == S_EXEC) ? FW'(fi_r) : f_r;
  assign uaddr  = UAW'(32'(uid_r) * amfu_pkg::FEATS_PER_ROW + 32'(fsel));
  assign iaddr  = IAW'(32'(iid_r) * amfu_pkg::FEATS_PER_ROW + 32'(fsel));

  assign own     = side_r ? v_r : u_r;
  assign other   = side_r ? u_r : v_r;
  assign acc_sel = side_r ? ai_r : au_r;

  assign ediff = 48'(sum_r) - (48'(rating_r) <<< 12) + 48'sd2048;
  assign gsum  = 48'(p1_r) + (48'(p2_r) <<< 4) + 48'sd32768;
  assign sqr   = (sq_r + 32'd128) >> 8;
  assign a33   = {1'b0, acc_sel} + {1'b0, sqr};
  assign a_nz  = (a_r == 32'd0) ? 32'd1 : a_r;
  assign nwide = (56'(own) <<< 16) - 56'(prod_r) + 56'sd32768;
  assign nf    = amfu_pkg::sat16(48'(nwide >>> 16));

  assign srem_sh = {srem_r[24:0], x_r[47:46]};
  assign strial  = {1'b0, root_r, 2'b01};
  assign drem_sh = {drem_r[23:0], num_r[31]};

  assign is_load = state_r == S_EXEC;
  assign uwe = (is_load && req_r == amfu_pkg::REQ_LOAD_USER && u_ok && f_ok)
            || (state_r == S_WB && !side_r);
  assign iwe = (is_load && req_r == amfu_pkg::REQ_LOAD_ITEM && i_ok && f_ok)
            || (state_r == S_WB && side_r);
  assign fwd = is_load ? lv_r : nf;
  assign awd = is_load ? 32'd0 : a_r;

  always_ff @(posedge clk) begin
    uf_rd_r <= uf_mem[uaddr];
    ua_rd_r <= ua_mem[uaddr];
    if (uwe) begin
      uf_mem[uaddr] <= fwd;
      ua_mem[uaddr] <= awd;
    end
  end

  always_ff @(posedge clk) begin
    if_rd_r <= if_mem[iaddr];
    ia_rd_r <= ia_mem[iaddr];
    if (iwe) begin
      if_mem[iaddr] <= fwd;
      ia_mem[iaddr] <= awd;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= amfu_pkg::LR_RESET;
      rf_r <= amfu_pkg::REG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        amfu_pkg::CFG_LEARNING_RATE: lr_r <= cfg_data;
        amfu_pkg::CFG_REG_FACTOR:    rf_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall       = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_error      = out_error_r;
  assign out_read_value = out_read_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      pv_r        <= 1'b0;
      side_r      <= 1'b0;
      f_r         <= '0;
      it_r        <= '0;
    end else begin
      rdv_r <= state_r == S_DOT;
      pv_r  <= rdv_r;
      if (rdv_r) begin
        dot_r <= $signed(uf_rd_r) * $signed(if_rd_r);
      end
      if (pv_r) begin
        sum_r <= sum_r + SW'(dot_r);
      end
      if (done_r && (!out_valid_r || !out_stall)) begin
        out_valid_r      <= 1'b1;
        out_error_r      <= err_r;
        out_read_value_r <= rd_val_r;
        done_r           <= 1'b0;
        state_r          <= S_IDLE;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r    <= in_req_type;
            uid_r    <= in_user_id;
            iid_r    <= in_item_id;
            fi_r     <= in_feature_index;
            lv_r     <= in_load_value;
            rating_r <= in_rating;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          err_r    <= '0;
          rd_val_r <= '0;
          f_r      <= '0;
          sum_r    <= '0;
          if (req_r == amfu_pkg::REQ_TRAIN && u_ok && i_ok) begin
            state_r <= S_DOT;
          end else if ((req_r == amfu_pkg::REQ_READ_USER && u_ok && f_ok)
                    || (req_r == amfu_pkg::REQ_READ_ITEM && i_ok && f_ok)) begin
            state_r <= S_RWAIT;
          end else begin
            done_r  <= 1'b1;
            state_r <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          if (!done_r) begin
            rd_val_r <= (req_r == amfu_pkg::REQ_READ_USER) ? $signed(uf_rd_r)
                                                           : $signed(if_rd_r);
            done_r   <= 1'b1;
          end
        end
        S_DOT: begin
          if (f_last) begin
            state_r <= S_DRAIN;
          end else begin
            f_r <= f_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!rdv_r && !pv_r) begin
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          err_r   <= amfu_pkg::sat16(ediff >>> 12);
          f_r     <= '0;
          state_r <= S_FRD;
        end
        S_FRD: state_r <= S_FLAT;
        S_FLAT: begin
          u_r     <= $signed(uf_rd_r);
          v_r     <= $signed(if_rd_r);
          au_r    <= ua_rd_r;
          ai_r    <= ia_rd_r;
          side_r  <= 1'b0;
          state_r <= S_GMUL;
        end
        S_GMUL: begin
          p1_r    <= $signed({1'b0, rf_r}) * own;
          p2_r    <= err_r * other;
          state_r <= S_GSUM;
        end
        S_GSUM: begin
          g_r     <= amfu_pkg::sat16(gsum >>> 16);
          state_r <= S_SQ;
        end
        S_SQ: begin
          sq_r    <= 32'(g_r * g_r);
          state_r <= S_ACC;
        end
        S_ACC: begin
          a_r     <= a33[32] ? 32'hffff_ffff : a33[31:0];
          state_r <= S_SQRT;
          it_r    <= '0;
          root_r  <= '0;
          srem_r  <= '0;
          x_r     <= '0;
        end
        S_SQRT: begin
          if (it_r == '0 && root_r == '0 && srem_r == '0 && x_r == '0) begin
            x_r <= {a_nz, 16'h0000};
            it_r <= ITW'(1);
          end else begin
            x_r <= {x_r[45:0], 2'b00};
            if (srem_sh >= strial) begin
              srem_r <= srem_sh - strial;
              root_r <= {root_r[22:0], 1'b1};
            end else begin
              srem_r <= srem_sh;
              root_r <= {root_r[22:0], 1'b0};
            end
            if (it_r == ITW'(amfu_pkg::SQRT_STEPS)) begin
              it_r    <= '0;
              num_r   <= {lr_r, 16'h0000};
              drem_r  <= '0;
              q_r     <= '0;
              state_r <= S_DIV;
            end else begin
              it_r <= it_r + 1'b1;
            end
          end
        end
        S_DIV: begin
          num_r <= {num_r[30:0], 1'b0};
          if (drem_sh >= {1'b0, root_r}) begin
            drem_r <= drem_sh - {1'b0, root_r};
            q_r    <= {q_r[30:0], 1'b1};
          end else begin
            drem_r <= drem_sh;
            q_r    <= {q_r[30:0], 1'b0};
          end
          if (it_r == ITW'(amfu_pkg::DIV_STEPS - 1)) begin
            it_r    <= '0;
            state_r <= S_UPD;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        S_UPD: begin
          prod_r  <= $signed({1'b0, q_r}) * g_r;
          state_r <= S_WB;
        end
        S_WB: begin
          if (!side_r) begin
            side_r  <= 1'b1;
            state_r <= S_GMUL;
          end else if (f_last) begin
            done_r  <= 1'b1;
            state_r <= S_RWAIT;
          end else begin
            f_r     <= f_r + 1'b1;
            state_r <= S_FRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> it_r <= ITW'(amfu_pkg::SQRT_STEPS))
    else $error("square root ran past its step count");

  a_item_follows_user: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && !side_r) |=> (state_r == S_GMUL && side_r))
    else $error("item element update did not follow the user element");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> root_r != '0)
    else $error("divider started with a zero divisor");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && out_valid_r && out_stall) |=> done_r)
    else $error("finished result dropped while the output word was stalled");

endmodule
